>>> rtl/md5s_pkg.sv
// md5s_pkg: shared types, constants and round tables of the md5 stream hasher
// no dependencies; imported by md5s_compress, md5_stream_hasher_top, md5_digest_checker and testbench
`default_nettype none

package md5s_pkg;

	localparam int WORD_W  = 32;
	localparam int WORDS   = 16;
	localparam int ADDR_W  = $clog2(WORDS);

	localparam logic [WORD_W-1:0] INIT_A = 32'h67452301;
	localparam logic [WORD_W-1:0] INIT_B = 32'hefcdab89;
	localparam logic [WORD_W-1:0] INIT_C = 32'h98badcfe;
	localparam logic [WORD_W-1:0] INIT_D = 32'h10325476;
	localparam logic [7:0]        PAD_MARK = 8'h80;

	localparam logic [ADDR_W-1:0] LEN_LO_IDX   = 4'd14;
	localparam logic [ADDR_W-1:0] LEN_HI_IDX   = 4'd15;
	localparam logic [ADDR_W-1:0] LAST_PAD_IDX = 4'd13;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] digest_a;
		logic [WORD_W-1:0] digest_b;
		logic [WORD_W-1:0] digest_c;
		logic [WORD_W-1:0] digest_d;
		logic              failed;
	} digest_word_t;

	typedef struct packed {
		logic start;
		logic init;
	} comp_ctl_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
	} comp_sts_t;

	function automatic logic [WORD_W-1:0] round_const(input logic [5:0] i);
		logic [WORD_W-1:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
			4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
		endcase
		return s;
	endfunction

	// message word used in each round, all arithmetic modulo 16
	function automatic logic [ADDR_W-1:0] msg_index(input logic [5:0] i);
		logic [ADDR_W-1:0] g;
		case (i[5:4])
			2'd0:    g = i[3:0];
			2'd1:    g = i[3:0] * 4'd5 + 4'd1;
			2'd2:    g = i[3:0] * 4'd3 + 4'd5;
			default: g = i[3:0] * 4'd7;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

>>> rtl/md5s_ram.sv
// md5s_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module md5s_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/md5s_compress.sv
// md5s_compress: chaining words and the one-round-per-cycle md5 compression
// depends on md5s_pkg; reads message words from the block ram
`default_nettype none

module md5s_compress
	import md5s_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire comp_ctl_t         ctl,
	output logic      [ADDR_W-1:0] raddr,
	input  wire logic [WORD_W-1:0] rdata,
	output comp_sts_t              sts
);

	logic              run_q, fin_q;
	logic [5:0]        round_q;
	logic [WORD_W-1:0] a_q, b_q, c_q, d_q;
	logic [WORD_W-1:0] ca_q, cb_q, cc_q, cd_q;
	logic [WORD_W-1:0] f, fsum, rot;
	logic [2*WORD_W-1:0] dbl;

	// address one round ahead to cover the ram read latency
	assign raddr = ctl.start ? '0 : msg_index(round_q + 6'd1);

	always_comb begin
		case (round_q[5:4])
			2'd0:    f = d_q ^ (b_q & (c_q ^ d_q));
			2'd1:    f = c_q ^ (d_q & (b_q ^ c_q));
			2'd2:    f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		fsum = f + a_q + round_const(round_q) + rdata;
		dbl  = {fsum, fsum} << rot_amount(round_q);
		rot  = dbl[2*WORD_W-1:WORD_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			fin_q   <= 1'b0;
			round_q <= '0;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
			ca_q    <= INIT_A;
			cb_q    <= INIT_B;
			cc_q    <= INIT_C;
			cd_q    <= INIT_D;
		end else begin
			fin_q <= 1'b0;
			if (ctl.init) begin
				ca_q <= INIT_A;
				cb_q <= INIT_B;
				cc_q <= INIT_C;
				cd_q <= INIT_D;
			end else if (fin_q) begin
				ca_q <= ca_q + a_q;
				cb_q <= cb_q + b_q;
				cc_q <= cc_q + c_q;
				cd_q <= cd_q + d_q;
			end
			if (ctl.start) begin
				run_q   <= 1'b1;
				round_q <= '0;
				a_q     <= ca_q;
				b_q     <= cb_q;
				c_q     <= cc_q;
				d_q     <= cd_q;
			end else if (run_q) begin
				a_q     <= d_q;
				b_q     <= b_q + rot;
				c_q     <= b_q;
				d_q     <= c_q;
				round_q <= round_q + 6'd1;
				if (round_q == 6'd63) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	assign sts.done = fin_q;
	assign sts.a    = ca_q;
	assign sts.b    = cb_q;
	assign sts.c    = cc_q;
	assign sts.d    = cd_q;

endmodule

`default_nettype wire

>>> rtl/md5_stream_hasher_top.sv
// md5_stream_hasher_top: byte packing, padding sequencer and digest output register
// depends on md5s_pkg, md5s_ram and md5s_compress
`default_nettype none

//  channel | handshake              | word
//  msg     | msg_valid / msg_stall  | msg_word_t: data_byte, has_byte, end_of_message
//  dig     | dig_valid / dig_stall  | digest_word_t: digest_a..d, failed
//
// a byte is taken each cycle while the sequencer is idle; every 64th byte starts the
// compression, which holds msg_stall high until the last round is done (one round
// per cycle through the shared round unit, message words read from the block ram)
// a final word adds the padding writes and one or two compressions (none for an
// empty message); the digest register frees the input side once loaded; reset
// returns the chaining words to their initial values and the byte count to zero

module md5_stream_hasher_top
	import md5s_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         msg_valid,
	output logic              msg_stall,
	input  wire msg_word_t    msg,
	output logic              dig_valid,
	input  wire logic         dig_stall,
	output digest_word_t      dig
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_COMP   = 7'b0000010,
		ST_MARK   = 7'b0000100,
		ST_ZERO   = 7'b0001000,
		ST_LEN_LO = 7'b0010000,
		ST_LEN_HI = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t            state_q, nxt_q;
	logic [63:0]       cnt_q, cnt_inc;
	logic [ADDR_W-1:0] widx_q;
	logic              fail_q, start_q, dig_valid_q;
	logic [WORD_W-1:0] word_q, word_n, mark_word;
	digest_word_t      dig_q;

	logic [5:0]        pos;
	logic              accept, load;
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [WORD_W-1:0] wdata, rdata;
	comp_ctl_t         ctl;
	comp_sts_t         sts;

	assign pos       = cnt_q[5:0];
	assign msg_stall = (state_q != ST_IDLE);
	assign accept    = msg_valid && (state_q == ST_IDLE);
	assign cnt_inc   = cnt_q + 64'(msg.has_byte);
	assign load      = (state_q == ST_DONE) && (!dig_valid_q || !dig_stall);

	// byte lanes above the current one stay zero, which the padding relies on
	always_comb begin
		case (pos[1:0])
			2'd0:    word_n = {24'b0, msg.data_byte};
			2'd1:    word_n = {16'b0, msg.data_byte, word_q[7:0]};
			2'd2:    word_n = {8'b0, msg.data_byte, word_q[15:0]};
			default: word_n = {msg.data_byte, word_q[23:0]};
		endcase
		case (pos[1:0])
			2'd0:    mark_word = {24'b0, PAD_MARK};
			2'd1:    mark_word = {16'b0, PAD_MARK, word_q[7:0]};
			2'd2:    mark_word = {8'b0, PAD_MARK, word_q[15:0]};
			default: mark_word = {PAD_MARK, word_q[23:0]};
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = pos[5:2];
		wdata = word_n;
		unique case (state_q)
			ST_IDLE: begin
				we = accept && msg.has_byte && (pos[1:0] == 2'd3);
			end
			ST_MARK: begin
				we    = 1'b1;
				wdata = mark_word;
			end
			ST_ZERO: begin
				we    = 1'b1;
				waddr = widx_q;
				wdata = '0;
			end
			ST_LEN_LO: begin
				we    = 1'b1;
				waddr = LEN_LO_IDX;
				wdata = {cnt_q[28:0], 3'b000};
			end
			ST_LEN_HI: begin
				we    = 1'b1;
				waddr = LEN_HI_IDX;
				wdata = cnt_q[60:29];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nxt_q       <= ST_IDLE;
			cnt_q       <= '0;
			widx_q      <= '0;
			fail_q      <= 1'b0;
			start_q     <= 1'b0;
			dig_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (load) begin
				dig_valid_q <= 1'b1;
			end else if (!dig_stall) begin
				dig_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (msg.has_byte) begin
							cnt_q <= cnt_inc;
						end
						if (msg.has_byte && (pos == 6'd63)) begin
							start_q <= 1'b1;
							state_q <= ST_COMP;
							fail_q  <= (cnt_inc == '0);
							if (!msg.end_of_message) begin
								nxt_q <= ST_IDLE;
							end else if (cnt_inc == '0) begin
								nxt_q <= ST_DONE;
							end else begin
								nxt_q <= ST_MARK;
							end
						end else if (msg.end_of_message) begin
							fail_q  <= (cnt_inc == '0);
							state_q <= (cnt_inc == '0) ? ST_DONE : ST_MARK;
						end
					end
				end
				ST_MARK: begin
					fail_q <= 1'b0;
					if (pos[5:2] == LEN_HI_IDX) begin
						start_q <= 1'b1;
						state_q <= ST_COMP;
						nxt_q   <= ST_ZERO;
						widx_q  <= '0;
					end else if (pos[5:2] == LAST_PAD_IDX) begin
						state_q <= ST_LEN_LO;
					end else begin
						state_q <= ST_ZERO;
						widx_q  <= pos[5:2] + 4'd1;
					end
				end
				ST_ZERO: begin
					if (widx_q == LEN_HI_IDX) begin
						start_q <= 1'b1;
						state_q <= ST_COMP;
						nxt_q   <= ST_ZERO;
						widx_q  <= '0;
					end else if (widx_q == LAST_PAD_IDX) begin
						state_q <= ST_LEN_LO;
					end else begin
						widx_q <= widx_q + 4'd1;
					end
				end
				ST_LEN_LO: begin
					state_q <= ST_LEN_HI;
				end
				ST_LEN_HI: begin
					start_q <= 1'b1;
					state_q <= ST_COMP;
					nxt_q   <= ST_DONE;
				end
				ST_COMP: begin
					if (sts.done) begin
						state_q <= nxt_q;
					end
				end
				ST_DONE: begin
					if (load) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && msg.has_byte) begin
			word_q <= word_n;
		end
		if (load) begin
			dig_q.digest_a <= fail_q ? '0 : sts.a;
			dig_q.digest_b <= fail_q ? '0 : sts.b;
			dig_q.digest_c <= fail_q ? '0 : sts.c;
			dig_q.digest_d <= fail_q ? '0 : sts.d;
			dig_q.failed   <= fail_q;
		end
	end

	assign ctl.start = start_q;
	assign ctl.init  = load;
	assign dig_valid = dig_valid_q;
	assign dig       = dig_q;

	md5s_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WORDS)
	) u_block_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	md5s_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.raddr  (raddr),
		.rdata  (rdata),
		.sts    (sts)
	);

endmodule

`default_nettype wire

>>> verif/md5_digest_checker.sv
// md5_digest_checker: watches both channels of the md5 stream hasher, predicts each digest
// from the accepted message words and compares it with the digest the block returns
// depends on md5s_pkg for the channel word types
`timescale 1ns / 1ps

module md5_digest_checker
	import md5s_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         msg_valid,
	input  wire logic         msg_stall,
	input  wire msg_word_t    msg,
	input  wire logic         dig_valid,
	input  wire logic         dig_stall,
	input  wire digest_word_t dig,
	output int                mismatches,
	output int                pending
);

	localparam logic [31:0] SEED_A = 32'h67452301;
	localparam logic [31:0] SEED_B = 32'hefcdab89;
	localparam logic [31:0] SEED_C = 32'h98badcfe;
	localparam logic [31:0] SEED_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam int          LENGTH_POS = 56;

	// sine table of the standard, listed from round 0 upwards
	localparam logic [64*32-1:0] SINE_TABLE = {
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [16*5-1:0] SHIFT_TABLE = {
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	logic [31:0]  chain_state [4];
	logic [7:0]   block_bytes [64];
	logic [63:0]  byte_total;
	digest_word_t expected_digests [$];
	int           fault_count;
	int           queued;

	assign mismatches = fault_count;
	assign pending    = queued;

	function automatic void fold_block();
		logic [31:0] m [16];
		logic [31:0] a, b, c, d, f;
		int          i, g, s;
		for (i = 0; i < 16; i++)
			m[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
		a = chain_state[0];
		b = chain_state[1];
		c = chain_state[2];
		d = chain_state[3];
		for (i = 0; i < 64; i++) begin
			case (i / 16)
				0: begin
					f = d ^ (b & (c ^ d));
					g = i;
				end
				1: begin
					f = c ^ (d & (b ^ c));
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			f = f + a + SINE_TABLE[(63 - i) * 32 +: 32] + m[g];
			s = SHIFT_TABLE[(15 - ((i / 16) * 4 + i % 4)) * 5 +: 5];
			a = d;
			d = c;
			c = b;
			b = b + ((f << s) | (f >> (32 - s)));
		end
		chain_state[0] = chain_state[0] + a;
		chain_state[1] = chain_state[1] + b;
		chain_state[2] = chain_state[2] + c;
		chain_state[3] = chain_state[3] + d;
	endfunction

	function automatic void place_byte(input int pos, input logic [7:0] v);
		block_bytes[pos] = v;
		if (pos == 63)
			fold_block();
	endfunction

	function automatic void restart_message();
		chain_state[0] = SEED_A;
		chain_state[1] = SEED_B;
		chain_state[2] = SEED_C;
		chain_state[3] = SEED_D;
		byte_total = '0;
	endfunction

	// padding, length and last fold; an empty message gives the failure word
	function automatic digest_word_t close_message();
		digest_word_t r;
		logic [63:0]  bits;
		int           pos, k;
		r = '0;
		if (byte_total == 64'd0) begin
			r.failed = 1'b1;
		end else begin
			pos = int'(byte_total[5:0]);
			place_byte(pos, PAD_BYTE);
			pos = (pos + 1) % 64;
			while (pos != LENGTH_POS) begin
				place_byte(pos, 8'h00);
				pos = (pos + 1) % 64;
			end
			bits = byte_total << 3;
			for (k = 0; k < 8; k++)
				block_bytes[LENGTH_POS + k] = bits[8*k +: 8];
			fold_block();
			r.digest_a = chain_state[0];
			r.digest_b = chain_state[1];
			r.digest_c = chain_state[2];
			r.digest_d = chain_state[3];
		end
		restart_message();
		return r;
	endfunction

	function automatic void take_word(input msg_word_t w);
		if (w.has_byte) begin
			place_byte(int'(byte_total[5:0]), w.data_byte);
			byte_total = byte_total + 64'd1;
		end
		if (w.end_of_message)
			expected_digests.push_back(close_message());
	endfunction

	function automatic void check_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
			fault_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		digest_word_t want;
		if (!arst_n) begin
			restart_message();
			for (int k = 0; k < 64; k++)
				block_bytes[k] = 8'h00;
			expected_digests.delete();
			fault_count = 0;
			queued = 0;
		end else begin
			if (msg_valid && !msg_stall)
				take_word(msg);
			if (dig_valid && !dig_stall) begin
				if (expected_digests.size() == 0) begin
					$display("%0t: unexpected digest word, expected none, got %h", $time, dig);
					fault_count++;
				end else begin
					want = expected_digests.pop_front();
					check_field("digest_a", want.digest_a, dig.digest_a);
					check_field("digest_b", want.digest_b, dig.digest_b);
					check_field("digest_c", want.digest_c, dig.digest_c);
					check_field("digest_d", want.digest_d, dig.digest_d);
					check_field("failed", 32'(want.failed), 32'(dig.failed));
				end
			end
			queued = expected_digests.size();
		end
	end

endmodule

>>> verif/testbench.sv
// testbench: drives byte messages into md5_stream_hasher_top with random idling on both sides
// depends on md5s_pkg, the block's rtl and md5_digest_checker, which does all the checking
`timescale 1ns / 1ps

module testbench;
	import md5s_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         msg_valid = 1'b0;
	logic         msg_stall;
	msg_word_t    msg = '0;
	logic         dig_valid;
	logic         dig_stall = 1'b0;
	digest_word_t dig;
	int           mismatches;
	int           pending;
	bit           steady_input = 1'b0;

	md5_stream_hasher_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	md5_digest_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.msg        (msg),
		.dig_valid  (dig_valid),
		.dig_stall  (dig_stall),
		.dig        (dig),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_input || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic msg_word_t mk_word(input logic [7:0] d, input logic h, input logic e);
		msg_word_t w;
		w.data_byte      = d;
		w.has_byte       = h;
		w.end_of_message = e;
		return w;
	endfunction

	// valid stays high across back-to-back words, so it is only lowered ahead of a gap
	task automatic send_word(input msg_word_t w);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_valid <= 1'b1;
		msg       <= w;
		@(posedge clk);
		while (msg_stall)
			@(posedge clk);
	endtask

	// lower valid and let the checker log the last accepted word before waiting for pending to reach zero
	task automatic drain_digests();
		msg_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// random bytes with an occasional ignored word; the last byte or a bare word ends it
	task automatic send_message(input int len, input bit bare_end, inout int n_items);
		int k;
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 19) == 0)
				send_word(mk_word(8'($urandom), 1'b0, 1'b0));
			send_word(mk_word(8'($urandom), 1'b1, !bare_end && k == len - 1));
			n_items++;
		end
		if (bare_end || len == 0) begin
			send_word(mk_word(8'($urandom), 1'b0, 1'b1));
			n_items++;
		end
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 24);
		if (r < 78)
			return 0;
		if (r < 94) begin
			case ($urandom_range(0, 5))
				0: return 55;
				1: return 56;
				2: return 57;
				3: return 63;
				4: return 64;
				default: return 65;
			endcase
		end
		return $urandom_range(100, 130);
	endfunction

	initial begin
		int n_items, n_msgs;
		n_items = 0;
		n_msgs = 0;
		wait (arst_n);
		@(posedge clk);

		// empty message straight after reset, then an ignored word before another empty one
		send_word(mk_word(8'h00, 1'b0, 1'b1));
		send_word(mk_word(8'h5a, 1'b0, 1'b0));
		send_word(mk_word(8'hff, 1'b0, 1'b1));
		send_word(mk_word(8'h61, 1'b1, 1'b0));
		send_word(mk_word(8'h62, 1'b1, 1'b0));
		send_word(mk_word(8'h63, 1'b1, 1'b1));
		// final word carrying no byte
		send_word(mk_word(8'h00, 1'b1, 1'b0));
		send_word(mk_word(8'hff, 1'b1, 1'b0));
		send_word(mk_word(8'ha5, 1'b1, 1'b0));
		send_word(mk_word(8'h3c, 1'b0, 1'b1));
		drain_digests();
		send_word(mk_word(8'h80, 1'b1, 1'b1));
		send_word(mk_word(8'h7f, 1'b0, 1'b1));
		send_word(mk_word(8'hff, 1'b1, 1'b1));

		while (n_items < 550 || n_msgs < 20) begin
			steady_input = ($urandom_range(0, 4) == 0);
			send_message(pick_length(), 1'($urandom_range(0, 1)), n_items);
			n_msgs++;
			if ($urandom_range(0, 5) == 0)
				drain_digests();
		end

		drain_digests();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// digest side: short stalls mostly, some long ones, and calm stretches with none
	initial begin
		int r;
		forever begin
			r = $urandom_range(0, 9);
			if (r < 2) begin
				dig_stall <= 1'b0;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end else begin
				dig_stall <= 1'b1;
				if (r < 8)
					repeat ($urandom_range(1, 3)) @(posedge clk);
				else
					repeat ($urandom_range(20, 80)) @(posedge clk);
				dig_stall <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

endmodule

>>> md5_stream_hasher_top.f
rtl/md5s_pkg.sv
rtl/md5s_ram.sv
rtl/md5s_compress.sv
rtl/md5_stream_hasher_top.sv
verif/md5_digest_checker.sv
verif/testbench.sv
